// ----- src/gmv_pkg.sv -----
// Shared constants, command codes and control structs for the grid map view merge block.
`default_nettype none

package gmv_pkg;

    localparam int MAP_SIDE_DEF  = 64;
    localparam int MAP_MID_DEF   = 32;
    localparam int VIEW_ROWS_DEF = 7;

    localparam int SYM_W      = 8;
    localparam int VIEW_HALF  = 3;
    localparam int VIEW_WIDTH = 2 * VIEW_HALF + 1;
    localparam int VC_W       = 3;
    // signed coordinate width for pose, centre and view offsets
    localparam int COORD_W    = 10;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [SYM_W-1:0] SYM_UNKNOWN = 8'd63;

    localparam logic [2:0] CMD_FRAME   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_SNAP    = 3'd3;
    localparam logic [2:0] CMD_RESTORE = 3'd4;

    localparam logic [2:0] ORI_UP    = 3'd0;
    localparam logic [2:0] ORI_DOWN  = 3'd1;
    localparam logic [2:0] ORI_LEFT  = 3'd2;
    localparam logic [2:0] ORI_RIGHT = 3'd3;

    typedef struct packed {
        logic load;
        logic calc;
        logic access;
        logic merge;
        logic sweep;
        logic clear;
        logic out_load;
    } gmv_cmd_t;

    typedef struct packed {
        logic go_cell;
        logic go_sweep;
        logic sweep_done;
    } gmv_stat_t;

endpackage

`default_nettype wire

// ----- src/gmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/gmv_dp.sv -----
// Datapath: item registers, pose latches, view counters, cell addressing, sweeps and both grids.
`default_nettype none

module gmv_dp #(
    parameter int MAP_SIDE  = gmv_pkg::MAP_SIDE_DEF,
    parameter int MAP_MID   = gmv_pkg::MAP_MID_DEF,
    parameter int VIEW_ROWS = gmv_pkg::VIEW_ROWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire gmv_pkg::gmv_cmd_t               cmd,
    output gmv_pkg::gmv_stat_t                   stat,
    input  wire logic [gmv_pkg::IN_DATA_W-1:0]   in_data,
    input  wire logic [gmv_pkg::IN_USER_W-1:0]   in_user,
    output logic      [gmv_pkg::OUT_DATA_W-1:0]  out_data
);

    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int AW     = $clog2(MAP_SIDE);
    localparam int VR_W   = $clog2(VIEW_ROWS + 1);
    localparam int CW     = gmv_pkg::COORD_W;
    localparam int SW     = gmv_pkg::SYM_W;

    // latched item
    logic [2:0]        cmd_reg;
    logic [2:0]        ori_reg;
    logic signed [5:0] px_reg;
    logic signed [5:0] py_reg;
    logic [SW-1:0]     sym_reg;
    logic              first_reg;

    logic signed [CW-1:0] robot_row_reg, robot_row_next;
    logic signed [CW-1:0] robot_col_reg, robot_col_next;
    logic [VR_W-1:0]             vr_reg, vr_next;
    logic [gmv_pkg::VC_W-1:0]    vc_reg, vc_next;

    logic [AW-1:0]     row_reg, col_reg;
    logic              oor_reg, oor_next;
    logic [ADDR_W-1:0] addr_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] waddr_reg;

    logic [SW-1:0]     work_rd_reg, work_rd_next;
    logic              work_wr_reg, work_wr_next;
    logic [SW-1:0]     out_rd_reg;
    logic              out_oor_reg, out_wr_reg;

    logic              frame_ok, is_rw;
    logic [VR_W-1:0]           vr_use;
    logic [gmv_pkg::VC_W-1:0]  vc_use;
    logic signed [CW-1:0] mid_s, side_s, half_s, vr_s, vc_s;
    logic signed [CW-1:0] row_new, col_new, rr, cc, row_c, col_c;
    logic              oor_c;
    logic [ADDR_W-1:0] addr_c, cnt_addr;
    logic              cnt_live;

    logic              grid_we, snap_we;
    logic [ADDR_W-1:0] grid_waddr, snap_waddr, grid_raddr;
    logic [SW-1:0]     grid_wdata, snap_wdata, grid_rdata, snap_rdata;
    logic              merge_wr;

    assign frame_ok = (cmd_reg == gmv_pkg::CMD_FRAME) &&
                      (ori_reg == gmv_pkg::ORI_UP || ori_reg == gmv_pkg::ORI_DOWN ||
                       ori_reg == gmv_pkg::ORI_LEFT || ori_reg == gmv_pkg::ORI_RIGHT);
    assign is_rw    = (cmd_reg == gmv_pkg::CMD_READ) || (cmd_reg == gmv_pkg::CMD_WRITE);

    assign stat.go_cell    = frame_ok || is_rw;
    assign stat.go_sweep   = (cmd_reg == gmv_pkg::CMD_SNAP) || (cmd_reg == gmv_pkg::CMD_RESTORE);
    assign stat.sweep_done = (cnt_reg == CNT_W'(DEPTH)) && !pend_reg;

    assign out_data = {{(gmv_pkg::OUT_DATA_W - SW - 2){1'b0}}, out_wr_reg, out_oor_reg, out_rd_reg};

    // ---- cell coordinates ----
    assign vr_use = first_reg ? '0 : vr_reg;
    assign vc_use = first_reg ? '0 : vc_reg;
    assign mid_s  = CW'(MAP_MID);
    assign side_s = CW'(MAP_SIDE);
    assign half_s = CW'(gmv_pkg::VIEW_HALF);
    assign vr_s   = $signed(CW'(vr_use));
    assign vc_s   = $signed(CW'(vc_use));
    assign row_new = CW'(py_reg) + mid_s;
    assign col_new = CW'(px_reg) + mid_s;

    always_comb
    begin
        robot_row_next = robot_row_reg;
        robot_col_next = robot_col_reg;
        if (ori_reg == gmv_pkg::ORI_UP || ori_reg == gmv_pkg::ORI_DOWN)
        begin
            robot_row_next = row_new;
        end
        else
        begin
            robot_col_next = col_new;
        end
        rr = robot_row_next;
        cc = robot_col_next;
        if (is_rw)
        begin
            row_c = row_new;
            col_c = col_new;
        end
        else
        begin
            unique case (ori_reg)
                gmv_pkg::ORI_UP:
                begin
                    row_c = rr - vr_s;
                    col_c = cc - half_s + vc_s;
                end
                gmv_pkg::ORI_DOWN:
                begin
                    row_c = rr + vr_s;
                    col_c = cc + half_s - vc_s;
                end
                gmv_pkg::ORI_LEFT:
                begin
                    row_c = rr + half_s - vc_s;
                    col_c = cc - vr_s;
                end
                default:
                begin
                    row_c = rr - half_s + vc_s;
                    col_c = cc + vr_s;
                end
            endcase
        end
        oor_c = row_c[CW-1] || (row_c >= side_s) || col_c[CW-1] || (col_c >= side_s);
    end

    // view counter advance, wraps after the last view cell
    always_comb
    begin
        vr_next = vr_use;
        vc_next = vc_use;
        if (vc_use == gmv_pkg::VC_W'(gmv_pkg::VIEW_WIDTH - 1))
        begin
            vc_next = '0;
            vr_next = (vr_use == VR_W'(VIEW_ROWS - 1)) ? '0 : vr_use + 1'b1;
        end
        else
        begin
            vc_next = vc_use + 1'b1;
        end
    end

    assign addr_c = ADDR_W'(row_reg) * ADDR_W'(MAP_SIDE) + ADDR_W'(col_reg);

    // ---- sweep counter ----
    assign cnt_addr = cnt_reg[ADDR_W-1:0];
    assign cnt_live = (cnt_reg != CNT_W'(DEPTH));

    always_comb
    begin
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (cmd.calc)
        begin
            cnt_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.sweep)
        begin
            pend_next = cnt_live && !cmd.clear;
            if (cnt_live)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // ---- memory ports ----
    assign merge_wr = cmd.merge && (cmd_reg == gmv_pkg::CMD_FRAME) && !oor_reg &&
                      (grid_rdata == gmv_pkg::SYM_UNKNOWN) && (sym_reg != gmv_pkg::SYM_UNKNOWN);
    assign grid_raddr = cmd.sweep ? cnt_addr : addr_c;

    always_comb
    begin
        grid_we    = 1'b0;
        grid_waddr = addr_c;
        grid_wdata = sym_reg;
        snap_we    = 1'b0;
        snap_waddr = cnt_addr;
        snap_wdata = gmv_pkg::SYM_UNKNOWN;
        if (cmd.sweep && cmd.clear)
        begin
            grid_we    = cnt_live;
            grid_waddr = cnt_addr;
            grid_wdata = gmv_pkg::SYM_UNKNOWN;
            snap_we    = cnt_live;
        end
        else if (cmd.sweep)
        begin
            // copy writes the registered read data at the held address waddr_reg when pend_reg is set
            if (cmd_reg == gmv_pkg::CMD_SNAP)
            begin
                snap_we    = pend_reg;
                snap_waddr = waddr_reg;
                snap_wdata = grid_rdata;
            end
            else
            begin
                grid_we    = pend_reg;
                grid_waddr = waddr_reg;
                grid_wdata = snap_rdata;
            end
        end
        else if (cmd.access)
        begin
            grid_we = (cmd_reg == gmv_pkg::CMD_WRITE) && !oor_reg;
        end
        else if (merge_wr)
        begin
            grid_we    = 1'b1;
            grid_waddr = addr_reg;
        end
    end

    // ---- result ----
    always_comb
    begin
        work_rd_next = work_rd_reg;
        work_wr_next = work_wr_reg;
        oor_next     = oor_reg;
        if (cmd.calc)
        begin
            work_rd_next = '0;
            work_wr_next = 1'b0;
            oor_next     = stat.go_cell && oor_c;
        end
        else if (cmd.access)
        begin
            work_wr_next = (cmd_reg == gmv_pkg::CMD_WRITE) && !oor_reg;
        end
        else if (cmd.merge)
        begin
            if (cmd_reg == gmv_pkg::CMD_READ && !oor_reg)
            begin
                work_rd_next = grid_rdata;
            end
            work_wr_next = work_wr_reg || merge_wr;
        end
    end

    gmv_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    gmv_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .raddr (cnt_addr),
        .rdata (snap_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_row_reg <= CW'(MAP_MID);
            robot_col_reg <= CW'(MAP_MID);
            vr_reg        <= '0;
            vc_reg        <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            if (cmd.calc && frame_ok)
            begin
                robot_row_reg <= robot_row_next;
                robot_col_reg <= robot_col_next;
                vr_reg        <= vr_next;
                vc_reg        <= vc_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_user;
            ori_reg   <= in_data[2:0];
            px_reg    <= in_data[8:3];
            py_reg    <= in_data[14:9];
            sym_reg   <= in_data[22:15];
            first_reg <= in_data[23];
        end
        if (cmd.calc)
        begin
            row_reg <= row_c[AW-1:0];
            col_reg <= col_c[AW-1:0];
        end
        if (cmd.access)
        begin
            addr_reg <= addr_c;
        end
        waddr_reg   <= cnt_addr;
        oor_reg     <= oor_next;
        work_rd_reg <= work_rd_next;
        work_wr_reg <= work_wr_next;
        if (cmd.out_load)
        begin
            out_rd_reg  <= work_rd_reg;
            out_oor_reg <= oor_reg;
            out_wr_reg  <= work_wr_reg;
        end
    end

    a_merge_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> $past(cmd.access))
        else $error("merge step without preceding access");

    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg < gmv_pkg::VC_W'(gmv_pkg::VIEW_WIDTH)) && (vr_reg < VR_W'(VIEW_ROWS)))
        else $error("view counter out of range");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("sweep counter past grid end");

endmodule

`default_nettype wire

// ----- src/gmv_ctrl.sv -----
// Controller: sequences clearing, per-item cell access, grid copies and result hand-off.
`default_nettype none

module gmv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gmv_pkg::gmv_cmd_t       cmd,
    input  wire gmv_pkg::gmv_stat_t stat
);

    typedef enum logic [2:0] {
        C_CLEAR,
        C_IDLE,
        C_CALC,
        C_ACCESS,
        C_MERGE,
        C_COPY,
        C_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_fire;

    assign in_ready  = (state_reg == C_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = m_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            C_CLEAR:
            begin
                cmd.sweep = 1'b1;
                cmd.clear = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = C_IDLE;
                end
            end
            C_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = C_CALC;
                end
            end
            C_CALC:
            begin
                cmd.calc = 1'b1;
                priority if (stat.go_cell)
                begin
                    state_next = C_ACCESS;
                end
                else if (stat.go_sweep)
                begin
                    state_next = C_COPY;
                end
                else
                begin
                    state_next = C_DONE;
                end
            end
            C_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = C_MERGE;
            end
            C_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = C_DONE;
            end
            C_COPY:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                // result register free or emptying this beat
                if (!m_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_fire_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == C_CALC))
        else $error("accepted beat not processed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- src/grid_map_view_merge.sv -----
// Top level: symbol grid map with view merge, single-cell access and snapshot copies.
// Usage:
//   Input beats arrive on s_axis; tuser carries the command, tdata the pose,
//   orientation, symbol and first-cell flag. Every accepted beat yields exactly
//   one result beat on m_axis (read symbol, out-of-range flag, cell-written flag).
//   Items are handled one at a time by a controller stepping a shared datapath.
//   Frame-cell, read and write items step through address calculation, cell
//   address/read, merge write and hand-off to the result register, then the
//   controller returns to idle, where it accepts the next beat;
//   the grid's single read port and registered read set the read-modify-write.
//   Snapshot and restore sweep the whole grid, one cell per cycle, then flush
//   the copy before the result is loaded. Other items go from address
//   calculation straight to hand-off.
//   After reset both grids are filled with the unknown symbol by a clearing
//   pass during which s_axis_tready stays low.
//   The pose latches return to the map centre and the view counter to zero.
//   A finished result waits in the output register; the next beat is still
//   accepted and processed, then holds until the waiting result is taken.
`default_nettype none

module grid_map_view_merge #(
    parameter int MAP_SIDE  = gmv_pkg::MAP_SIDE_DEF,
    parameter int MAP_MID   = gmv_pkg::MAP_MID_DEF,
    parameter int VIEW_ROWS = gmv_pkg::VIEW_ROWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // orientation[2:0], pos_x[8:3], pos_y[14:9], symbol[22:15], first_cell[23]
    input  wire logic [gmv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[2:0]
    input  wire logic [gmv_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_symbol[7:0], out_of_range[8], cell_written[9], zero[15:10]
    output logic      [gmv_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    gmv_pkg::gmv_cmd_t  cmd;
    gmv_pkg::gmv_stat_t stat;

    gmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gmv_dp #(
        .MAP_SIDE  (MAP_SIDE),
        .MAP_MID   (MAP_MID),
        .VIEW_ROWS (VIEW_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire
